### rtl/core/tcptq_pkg.sv
package tcptq_pkg;

    localparam int CLASS_DEPTH = 16;
    localparam int NUM_CLASSES = 3;
    localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
    localparam int TOT_W       = CNT_W + 2;
    localparam int ADDR_W      = $clog2(NUM_CLASSES * CLASS_DEPTH);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 16;
    localparam int ENTRY_W     = ID_W + TIME_W;

    localparam logic [1:0] CLS_DOWNLOAD = 2'd0;
    localparam logic [1:0] CLS_MUSIC    = 2'd1;
    localparam logic [1:0] CLS_GAME     = 2'd2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_stat;

endpackage

### rtl/core/tcptq_ctrl.sv
module tcptq_ctrl
    import tcptq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_blocked) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.latch_in = i_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_FIN: begin
                o_cmd.load_out = !i_stat.out_blocked;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/tcptq_dp.sv
module tcptq_dp
    import tcptq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_func,
    input  logic [1:0]  i_task_class,
    input  logic [15:0] i_exec_time,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_task_id,
    output logic [1:0]  o_out_class,
    output logic [15:0] o_out_time,
    output logic        o_level_change,
    output logic [4:0]  o_count_download,
    output logic [4:0]  o_count_music,
    output logic [4:0]  o_count_game,
    output logic [5:0]  o_count_total
);

    // Request registers.
    logic              r_in_func;
    logic [1:0]        r_in_class;
    logic [TIME_W-1:0] r_in_time;

    // Queue state.
    logic [PTR_W-1:0]  r_head  [NUM_CLASSES];
    logic [CNT_W-1:0]  r_count [NUM_CLASSES];
    logic [ID_W-1:0]   r_next_id;
    logic [ENTRY_W-1:0] r_mem  [NUM_CLASSES * CLASS_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // Result held between execution and output load.
    t_status           r_p_status;
    logic [ID_W-1:0]   r_p_id;
    logic [1:0]        r_p_class;
    logic [TIME_W-1:0] r_p_time;
    logic              r_p_lchg;
    logic              r_p_from_mem;

    // Output register.
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [ID_W-1:0]   r_o_id;
    logic [1:0]        r_o_class;
    logic [TIME_W-1:0] r_o_time;
    logic              r_o_lchg;
    logic [4:0]        r_o_cnt [NUM_CLASSES];
    logic [5:0]        r_o_total;

    logic              push_cls_ok;
    logic [CNT_W-1:0]  push_cnt;
    logic [PTR_W-1:0]  push_head;
    logic              push_ok;
    logic [CNT_W:0]    push_sum;
    logic [PTR_W-1:0]  push_slot;
    logic [ADDR_W-1:0] push_addr;
    logic              pop_any;
    logic [1:0]        pop_cls;
    logic [PTR_W-1:0]  pop_head;
    logic [ADDR_W-1:0] pop_addr;
    logic [PTR_W-1:0]  pop_head_nxt;
    logic [CNT_W-1:0]  aft_cnt [NUM_CLASSES];
    logic              nxt_any;
    logic [1:0]        nxt_cls;
    logic              pop_lchg;
    logic [ID_W-1:0]   id_inc;
    logic [TOT_W-1:0]  total;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        push_cls_ok = 1'b1;
        push_cnt    = '0;
        push_head   = '0;
        case (r_in_class)
            CLS_DOWNLOAD: begin
                push_cnt  = r_count[0];
                push_head = r_head[0];
            end
            CLS_MUSIC: begin
                push_cnt  = r_count[1];
                push_head = r_head[1];
            end
            CLS_GAME: begin
                push_cnt  = r_count[2];
                push_head = r_head[2];
            end
            default: begin
                push_cls_ok = 1'b0;
            end
        endcase
        push_ok  = push_cls_ok && (push_cnt < CNT_W'(CLASS_DEPTH));
        push_sum = (CNT_W + 1)'(push_head) + (CNT_W + 1)'(push_cnt);
        if (push_sum >= (CNT_W + 1)'(CLASS_DEPTH)) begin
            push_slot = PTR_W'(push_sum - (CNT_W + 1)'(CLASS_DEPTH));
        end else begin
            push_slot = PTR_W'(push_sum);
        end
        push_addr = ADDR_W'(r_in_class) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(push_slot);
    end

    // Strict priority: download first, then music, then game.
    always_comb begin
        pop_any = (r_count[0] != '0) || (r_count[1] != '0) || (r_count[2] != '0);
        if (r_count[0] != '0) begin
            pop_cls  = CLS_DOWNLOAD;
            pop_head = r_head[0];
        end else if (r_count[1] != '0) begin
            pop_cls  = CLS_MUSIC;
            pop_head = r_head[1];
        end else begin
            pop_cls  = CLS_GAME;
            pop_head = r_head[2];
        end
        pop_addr = ADDR_W'(pop_cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(pop_head);
        if (pop_head == PTR_W'(CLASS_DEPTH - 1)) begin
            pop_head_nxt = '0;
        end else begin
            pop_head_nxt = pop_head + PTR_W'(1);
        end
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (pop_any && (pop_cls == 2'(c))) begin
                aft_cnt[c] = r_count[c] - CNT_W'(1);
            end else begin
                aft_cnt[c] = r_count[c];
            end
        end
        nxt_any = (aft_cnt[0] != '0) || (aft_cnt[1] != '0) || (aft_cnt[2] != '0);
        if (aft_cnt[0] != '0) begin
            nxt_cls = CLS_DOWNLOAD;
        end else if (aft_cnt[1] != '0) begin
            nxt_cls = CLS_MUSIC;
        end else begin
            nxt_cls = CLS_GAME;
        end
        pop_lchg = pop_any && nxt_any && (nxt_cls != pop_cls);
    end

    // Id zero means no task, so the counter skips it on wrap.
    assign id_inc  = (r_next_id == {ID_W{1'b1}}) ? ID_W'(1) : r_next_id + ID_W'(1);
    assign total   = TOT_W'(r_count[0]) + TOT_W'(r_count[1]) + TOT_W'(r_count[2]);
    assign do_push = i_cmd.exec && (r_in_func == FUNC_PUSH) && push_ok;
    assign do_pop  = i_cmd.exec && (r_in_func == FUNC_POP) && pop_any;

    assign o_stat.out_blocked = r_out_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_func  <= i_func;
            r_in_class <= i_task_class;
            r_in_time  <= i_exec_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[push_addr] <= {r_next_id, r_in_time};
        end
        if (i_cmd.exec && (r_in_func == FUNC_POP)) begin
            r_rdata <= r_mem[pop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
            r_next_id <= ID_W'(1);
        end else if (do_push) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (r_in_class == 2'(c)) begin
                    r_count[c] <= r_count[c] + CNT_W'(1);
                end
            end
            r_next_id <= id_inc;
        end else if (do_pop) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_count[c] <= aft_cnt[c];
                if (pop_cls == 2'(c)) begin
                    r_head[c] <= pop_head_nxt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_in_func == FUNC_PUSH) begin
                r_p_status   <= push_ok ? STAT_OK : STAT_FULL;
                r_p_id       <= push_ok ? r_next_id : '0;
                r_p_class    <= r_in_class;
                r_p_time     <= push_ok ? r_in_time : '0;
                r_p_lchg     <= 1'b0;
                r_p_from_mem <= 1'b0;
            end else begin
                r_p_status   <= pop_any ? STAT_OK : STAT_EMPTY;
                r_p_id       <= '0;
                r_p_class    <= pop_any ? pop_cls : CLS_DOWNLOAD;
                r_p_time     <= '0;
                r_p_lchg     <= pop_lchg;
                r_p_from_mem <= pop_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_p_status;
            r_o_id     <= r_p_from_mem ? r_rdata[ENTRY_W-1:TIME_W] : r_p_id;
            r_o_class  <= r_p_class;
            r_o_time   <= r_p_from_mem ? r_rdata[TIME_W-1:0] : r_p_time;
            r_o_lchg   <= r_p_lchg;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_o_cnt[c] <= 5'(r_count[c]);
            end
            r_o_total  <= 6'(total);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_o_status;
    assign o_task_id        = r_o_id;
    assign o_out_class      = r_o_class;
    assign o_out_time       = r_o_time;
    assign o_level_change   = r_o_lchg;
    assign o_count_download = r_o_cnt[0];
    assign o_count_music    = r_o_cnt[1];
    assign o_count_game     = r_o_cnt[2];
    assign o_count_total    = r_o_total;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= CNT_W'(CLASS_DEPTH)) && (r_count[1] <= CNT_W'(CLASS_DEPTH))
        && (r_count[2] <= CNT_W'(CLASS_DEPTH)))
        else $error("class count above depth");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("next id is zero");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_out && r_out_valid && !i_ready))
        else $error("result loaded over a waiting result");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> (total == $past(total) - TOT_W'(1)))
        else $error("pop did not remove exactly one task");

endmodule

### rtl/core/three_class_priority_task_queue.sv
// Each request is latched into the input registers, executed into the held result
// registers and then loaded into the output register; a result that cannot load
// because the previous result still waits on i_ready holds the block back.
// The next request is taken once the previous result sits in the output register.
// Reset (synchronous, active low) empties all classes and restarts ids at 1;
// the task memory is not cleared, since only written entries are ever read.
module three_class_priority_task_queue
    import tcptq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [1:0]  i_task_class,
    input  logic [15:0] i_exec_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_task_id,
    output logic [1:0]  o_out_class,
    output logic [15:0] o_out_time,
    output logic        o_level_change,
    output logic [4:0]  o_count_download,
    output logic [4:0]  o_count_music,
    output logic [4:0]  o_count_game,
    output logic [5:0]  o_count_total
);

    t_cmd  cmd;
    t_stat stat;

    tcptq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tcptq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_func           (i_func),
        .i_task_class     (i_task_class),
        .i_exec_time      (i_exec_time),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_task_id        (o_task_id),
        .o_out_class      (o_out_class),
        .o_out_time       (o_out_time),
        .o_level_change   (o_level_change),
        .o_count_download (o_count_download),
        .o_count_music    (o_count_music),
        .o_count_game     (o_count_game),
        .o_count_total    (o_count_total)
    );

endmodule

### sim/three_class_priority_task_queue_tb.sv
module three_class_priority_task_queue_tb;
    import tcptq_pkg::*;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] secs;
    } t_task_rec;

    typedef struct packed {
        t_status     status;
        logic [15:0] id;
        logic [1:0]  cls;
        logic [15:0] secs;
        logic        lvl_chg;
        logic [4:0]  n_download;
        logic [4:0]  n_music;
        logic [4:0]  n_game;
        logic [5:0]  n_all;
    } t_reply;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_func         = FUNC_PUSH;
    logic [1:0]  i_task_class   = CLS_DOWNLOAD;
    logic [15:0] i_exec_time    = 16'd0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_task_id;
    logic [1:0]  o_out_class;
    logic [15:0] o_out_time;
    logic        o_level_change;
    logic [4:0]  o_count_download;
    logic [4:0]  o_count_music;
    logic [4:0]  o_count_game;
    logic [5:0]  o_count_total;

    // Shadow copy of the queue contents, used to predict every reply.
    t_task_rec   slots [NUM_CLASSES][CLASS_DEPTH];
    int unsigned head_slot [NUM_CLASSES];
    int unsigned waiting [NUM_CLASSES];
    logic [15:0] next_task_id;

    t_reply replies_due [$];
    int     mismatch_count = 0;
    int     send_gap_pct   = 0;
    int     recv_stall_pct = 0;
    int     hold_request   = 0;
    int     hold_left      = 0;

    three_class_priority_task_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_task_class     (i_task_class),
        .i_exec_time      (i_exec_time),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_task_id        (o_task_id),
        .o_out_class      (o_out_class),
        .o_out_time       (o_out_time),
        .o_level_change   (o_level_change),
        .o_count_download (o_count_download),
        .o_count_music    (o_count_music),
        .o_count_game     (o_count_game),
        .o_count_total    (o_count_total)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int highest_waiting_class();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (waiting[c] != 0) return c;
        end
        return -1;
    endfunction

    function automatic t_reply predict_queue_op(logic func, logic [1:0] cls,
                                                logic [15:0] secs);
        t_reply    r;
        int        c;
        int        nxt;
        int        slot;
        t_task_rec rec;
        r        = '0;
        r.status = STAT_OK;
        if (func == FUNC_PUSH) begin
            r.cls = cls;
            c     = int'(cls);
            if (c >= NUM_CLASSES || waiting[c] >= CLASS_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                slot           = (head_slot[c] + waiting[c]) % CLASS_DEPTH;
                slots[c][slot] = '{id: next_task_id, secs: secs};
                waiting[c]++;
                r.id           = next_task_id;
                r.secs         = secs;
                next_task_id   = next_task_id + 16'd1;
                // Id zero means "no task", so the counter skips it on wrap.
                if (next_task_id == 16'd0) next_task_id = 16'd1;
            end
        end else begin
            c = highest_waiting_class();
            if (c < 0) begin
                r.status = STAT_EMPTY;
            end else begin
                rec          = slots[c][head_slot[c]];
                r.id         = rec.id;
                r.secs       = rec.secs;
                r.cls        = c[1:0];
                head_slot[c] = (head_slot[c] + 1) % CLASS_DEPTH;
                waiting[c]--;
                nxt          = highest_waiting_class();
                r.lvl_chg    = (nxt >= 0 && nxt != c);
            end
        end
        r.n_download = waiting[0][4:0];
        r.n_music    = waiting[1][4:0];
        r.n_game     = waiting[2][4:0];
        r.n_all      = 6'(waiting[0] + waiting[1] + waiting[2]);
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                 want);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected result (task_id)", o_task_id, 0);
            end else begin
                want = replies_due.pop_front();
                check_field("status", o_status, want.status);
                check_field("task_id", o_task_id, want.id);
                check_field("out_class", o_out_class, want.cls);
                check_field("out_time", o_out_time, want.secs);
                check_field("level_change", o_level_change, want.lvl_chg);
                check_field("count_download", o_count_download, want.n_download);
                check_field("count_music", o_count_music, want.n_music);
                check_field("count_game", o_count_game, want.n_game);
                check_field("count_total", o_count_total, want.n_all);
            end
        end
    end

    task automatic issue_request(logic func, logic [1:0] cls, logic [15:0] secs);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_task_class <= cls;
        i_exec_time  <= secs;
        do @(posedge i_clk); while (!o_ready);
        replies_due.push_back(predict_queue_op(func, cls, secs));
    endtask

    task automatic wait_replies_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    function automatic logic [15:0] random_secs();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Class 3 does not exist; it shows up now and then to exercise the refusal.
    function automatic logic [1:0] random_class();
        if ($urandom_range(19) == 0) return 2'd3;
        return 2'($urandom_range(2));
    endfunction

    task automatic test_empty_and_bad_class();
        issue_request(FUNC_POP, CLS_GAME, 16'hFFFF);
        issue_request(FUNC_PUSH, 2'd3, 16'h1234);
    endtask

    task automatic test_priority_and_order();
        issue_request(FUNC_PUSH, CLS_GAME, 16'h0000);
        issue_request(FUNC_PUSH, CLS_MUSIC, 16'hFFFF);
        issue_request(FUNC_PUSH, CLS_DOWNLOAD, 16'h0001);
        issue_request(FUNC_PUSH, CLS_DOWNLOAD, 16'h8000);
        repeat (4) issue_request(FUNC_POP, CLS_DOWNLOAD, 16'h0000);
    endtask

    task automatic test_class_full();
        repeat (CLASS_DEPTH + 1) issue_request(FUNC_PUSH, CLS_MUSIC, random_secs());
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        hold_request = 120;
        repeat (CLASS_DEPTH + 2) issue_request(FUNC_POP, random_class(), random_secs());
        repeat (6) issue_request(FUNC_PUSH, random_class(), random_secs());
        wait_replies_drained();
    endtask

    // Push bias drifts so the classes swing between empty and full.
    task automatic test_random_mix(int count, int gap_pct, int stall_pct);
        int push_bias;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        push_bias      = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) push_bias = $urandom_range(20, 85);
            if ($urandom_range(99) < push_bias) begin
                issue_request(FUNC_PUSH, random_class(), random_secs());
            end else begin
                issue_request(FUNC_POP, 2'($urandom_range(3)), 16'($urandom));
            end
        end
        wait_replies_drained();
    endtask

    initial begin
        int guard;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            head_slot[c] = 0;
            waiting[c]   = 0;
        end
        next_task_id = 16'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct   = 21;
        recv_stall_pct = 77;
        test_empty_and_bad_class();
        test_priority_and_order();
        test_class_full();
        test_backpressure();
        test_random_mix(400, 21, 77);
        test_random_mix(400, 77, 21);
        test_random_mix(400, 0, 0);

        i_valid <= 1'b0;
        guard = 0;
        while (replies_due.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (replies_due.size() != 0) begin
            report_mismatch("results never delivered (count)", 0, replies_due.size());
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
